// ===== rtl/ikev2_cap_pkg.sv =====
// Shared types and constants for the IKEv2 configuration attribute parser.
// No dependencies; used by the top level ikev2_config_attribute_parser.
`default_nettype none

package ikev2_cap_pkg;

  // Input word kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TAKE  = 2'd2;

  // Configuration payload types.
  localparam logic [7:0] PAYLOAD_REQUEST = 8'd1;
  localparam logic [7:0] PAYLOAD_REPLY   = 8'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_FORMAT  = 2'd2;

  // Address kinds held in the store.
  localparam logic [1:0] ADDR_NONE = 2'd0;
  localparam logic [1:0] ADDR_IP4  = 2'd1;
  localparam logic [1:0] ADDR_IP6  = 2'd2;

  // Attribute types with the R bit removed.
  localparam logic [14:0] ATTR_IP4_ADDRESS    = 15'd1;
  localparam logic [14:0] ATTR_IP4_DNS        = 15'd3;
  localparam logic [14:0] ATTR_ADDRESS_EXPIRY = 15'd5;
  localparam logic [14:0] ATTR_IP6_ADDRESS    = 15'd8;

  localparam logic [15:0] SHORT_VALUE_LEN = 16'd4;
  localparam logic [15:0] IP6_VALUE_LEN   = 16'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cfg_type;
    logic [15:0] area_length;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        drop_request;
    logic [1:0]  address_kind;
    logic [31:0] address_v4;
    logic [63:0] address_v6_high;
    logic [63:0] address_v6_low;
    logic [31:0] dns_first;
    logic [31:0] dns_second;
    logic [31:0] expiry;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/ikev2_config_attribute_parser.sv =====
// A result word is registered in the cycle after the input word that causes it is accepted.
// Throughput: one input word per cycle; a waiting result does not block input when
// the consumer takes it in the same cycle.
// Reset (rst, synchronous, active high) clears the parse state, the address, DNS and
// expiry store, and the result register.
// Depends on ikev2_cap_pkg.
`default_nettype none

module ikev2_config_attribute_parser (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire ikev2_cap_pkg::in_word_t in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output ikev2_cap_pkg::out_word_t     out_data
);

  logic         active, active_next;
  logic [15:0]  bytes_left, bytes_left_next;
  logic [1:0]   header_count, header_count_next;
  logic [14:0]  attr_type, attr_type_next;
  logic [15:0]  attr_length, attr_length_next;
  logic [15:0]  value_count, value_count_next;
  logic [127:0] vshift, vshift_next;
  logic         failed, failed_next;
  logic         is_reply, is_reply_next;
  logic [1:0]   addr_kind, addr_kind_next;
  logic [31:0]  addr_v4, addr_v4_next;
  logic [127:0] addr_v6, addr_v6_next;
  logic [31:0]  dns0, dns0_next;
  logic [31:0]  dns1, dns1_next;
  logic [31:0]  expiry_reg, expiry_reg_next;

  logic         accept;
  logic         emit;
  logic         take_sel;
  logic [1:0]   res_status;
  logic         res_drop;
  logic [15:0]  len_full;
  logic         short_attr;
  logic [31:0]  value32;
  ikev2_cap_pkg::out_word_t res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    active_next       = active;
    bytes_left_next   = bytes_left;
    header_count_next = header_count;
    attr_type_next    = attr_type;
    attr_length_next  = attr_length;
    value_count_next  = value_count;
    vshift_next       = vshift;
    failed_next       = failed;
    is_reply_next     = is_reply;
    addr_kind_next    = addr_kind;
    addr_v4_next      = addr_v4;
    addr_v6_next      = addr_v6;
    dns0_next         = dns0;
    dns1_next         = dns1;
    expiry_reg_next   = expiry_reg;
    emit              = 1'b0;
    take_sel          = 1'b0;
    res_status        = ikev2_cap_pkg::STATUS_OK;
    res_drop          = 1'b0;
    len_full          = {attr_length[15:8], in_data.data_byte};
    short_attr        = (attr_type == ikev2_cap_pkg::ATTR_IP4_ADDRESS) ||
                        (attr_type == ikev2_cap_pkg::ATTR_IP4_DNS) ||
                        (attr_type == ikev2_cap_pkg::ATTR_ADDRESS_EXPIRY);
    value32           = vshift_next[31:0];

    if (accept) begin
      unique case (in_data.kind)
        ikev2_cap_pkg::KIND_START: begin
          active_next       = 1'b0;
          header_count_next = 2'd0;
          attr_type_next    = '0;
          attr_length_next  = '0;
          value_count_next  = '0;
          vshift_next       = '0;
          failed_next       = 1'b0;
          if (in_data.cfg_type != ikev2_cap_pkg::PAYLOAD_REQUEST &&
              in_data.cfg_type != ikev2_cap_pkg::PAYLOAD_REPLY) begin
            bytes_left_next = '0;
            is_reply_next   = 1'b0;
            emit            = 1'b1;
            res_status      = ikev2_cap_pkg::STATUS_IGNORED;
          end else begin
            is_reply_next   = (in_data.cfg_type == ikev2_cap_pkg::PAYLOAD_REPLY);
            bytes_left_next = in_data.area_length;
            if (in_data.area_length == '0) begin
              emit = 1'b1;
            end else begin
              active_next = 1'b1;
            end
          end
        end
        ikev2_cap_pkg::KIND_BYTE: begin
          if (active) begin
            if (!failed) begin
              if (header_count == 2'd0 && value_count < attr_length) begin
                vshift_next      = {vshift[119:0], in_data.data_byte};
                value_count_next = 16'(value_count + 16'd1);
                value32          = vshift_next[31:0];
                if (value_count_next == attr_length) begin
                  // The value is complete: move it into the store.
                  if (attr_type == ikev2_cap_pkg::ATTR_IP4_ADDRESS) begin
                    addr_kind_next = ikev2_cap_pkg::ADDR_IP4;
                    addr_v4_next   = value32;
                    addr_v6_next   = '0;
                  end else if (attr_type == ikev2_cap_pkg::ATTR_IP4_DNS) begin
                    if (dns0 == '0) begin
                      dns0_next = value32;
                    end else if (dns1 == '0) begin
                      dns1_next = value32;
                    end
                  end else if (attr_type == ikev2_cap_pkg::ATTR_ADDRESS_EXPIRY) begin
                    expiry_reg_next = value32;
                  end else if (attr_type == ikev2_cap_pkg::ATTR_IP6_ADDRESS) begin
                    addr_kind_next = ikev2_cap_pkg::ADDR_IP6;
                    addr_v4_next   = '0;
                    addr_v6_next   = vshift_next;
                  end
                  attr_length_next = '0;
                  value_count_next = '0;
                end
              end else begin
                case (header_count)
                  2'd0: begin
                    attr_type_next    = {in_data.data_byte[6:0], 8'd0};
                    header_count_next = 2'd1;
                  end
                  2'd1: begin
                    attr_type_next    = {attr_type[14:8], in_data.data_byte};
                    header_count_next = 2'd2;
                  end
                  2'd2: begin
                    attr_length_next  = {in_data.data_byte, 8'd0};
                    header_count_next = 2'd3;
                  end
                  default: begin
                    attr_length_next  = len_full;
                    header_count_next = 2'd0;
                    value_count_next  = '0;
                    vshift_next       = '0;
                    if ((short_attr && len_full != '0 &&
                         len_full != ikev2_cap_pkg::SHORT_VALUE_LEN) ||
                        (attr_type == ikev2_cap_pkg::ATTR_IP6_ADDRESS && len_full != '0 &&
                         len_full != ikev2_cap_pkg::IP6_VALUE_LEN)) begin
                      failed_next = 1'b1;
                    end
                  end
                endcase
              end
            end
            bytes_left_next = 16'(bytes_left - 16'd1);
            if (bytes_left_next == '0) begin
              // Last byte of the area: a header or value still open is cut short.
              active_next = 1'b0;
              if (header_count_next != 2'd0 || value_count_next < attr_length_next) begin
                failed_next = 1'b1;
              end
              emit       = 1'b1;
              res_status = failed_next ? ikev2_cap_pkg::STATUS_FORMAT
                                       : ikev2_cap_pkg::STATUS_OK;
              res_drop   = failed_next && !is_reply;
            end
          end
        end
        ikev2_cap_pkg::KIND_TAKE: begin
          emit           = 1'b1;
          take_sel       = 1'b1;
          addr_kind_next = ikev2_cap_pkg::ADDR_NONE;
          addr_v4_next   = '0;
          addr_v6_next   = '0;
          dns0_next      = '0;
          dns1_next      = '0;
        end
        default: begin
        end
      endcase
    end

    // A take reports the store as it was before the clear.
    res.status          = res_status;
    res.drop_request    = res_drop;
    res.address_kind    = take_sel ? addr_kind      : addr_kind_next;
    res.address_v4      = take_sel ? addr_v4        : addr_v4_next;
    res.address_v6_high = take_sel ? addr_v6[127:64] : addr_v6_next[127:64];
    res.address_v6_low  = take_sel ? addr_v6[63:0]  : addr_v6_next[63:0];
    res.dns_first       = take_sel ? dns0           : dns0_next;
    res.dns_second      = take_sel ? dns1           : dns1_next;
    res.expiry          = expiry_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      bytes_left   <= '0;
      header_count <= 2'd0;
      attr_type    <= '0;
      attr_length  <= '0;
      value_count  <= '0;
      vshift       <= '0;
      failed       <= 1'b0;
      is_reply     <= 1'b0;
      addr_kind    <= ikev2_cap_pkg::ADDR_NONE;
      addr_v4      <= '0;
      addr_v6      <= '0;
      dns0         <= '0;
      dns1         <= '0;
      expiry_reg   <= '0;
      out_valid    <= 1'b0;
      out_data     <= '0;
    end else begin
      active       <= active_next;
      bytes_left   <= bytes_left_next;
      header_count <= header_count_next;
      attr_type    <= attr_type_next;
      attr_length  <= attr_length_next;
      value_count  <= value_count_next;
      vshift       <= vshift_next;
      failed       <= failed_next;
      is_reply     <= is_reply_next;
      addr_kind    <= addr_kind_next;
      addr_v4      <= addr_v4_next;
      addr_v6      <= addr_v6_next;
      dns0         <= dns0_next;
      dns1         <= dns1_next;
      expiry_reg   <= expiry_reg_next;
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
